// ===== rtl/plar_pkg.sv =====
package plar_pkg;

   // transaction action codes
   localparam logic [1:0] ACT_POLL   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_FORCE  = 2'd2;

   // resolved speed/duplex codes
   localparam logic [2:0] SPD_NONE  = 3'd0;
   localparam logic [2:0] SPD_10H   = 3'd1;
   localparam logic [2:0] SPD_10F   = 3'd2;
   localparam logic [2:0] SPD_100H  = 3'd3;
   localparam logic [2:0] SPD_100F  = 3'd4;
   localparam logic [2:0] SPD_1000H = 3'd5;
   localparam logic [2:0] SPD_1000F = 3'd6;

   // partner gigabit status is aligned to the local control bits by this shift
   localparam int unsigned GIG_STATUS_SHIFT = 2;

   // configuration register indexes
   localparam logic CSR_GIGABIT_ENABLED = 1'b0;
   localparam logic CSR_TIMEOUT_POLLS   = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd50;

   typedef enum logic [2:0] {
      ST_CHANGED     = 3'd0,
      ST_SAME        = 3'd1,
      ST_NEGOTIATING = 3'd2,
      ST_TIMEOUT     = 3'd3,
      ST_NOTSUP      = 3'd4
   } plar_status_type;

   typedef struct packed {
      logic        is_up;
      logic [2:0]  speed_code;
      logic        in_negotiation;
      logic [15:0] polls_waited;
   } plar_state_type;

   typedef struct packed {
      logic        gigabit_enabled;
      logic [15:0] autoneg_timeout_polls;
   } plar_cfg_type;

   typedef struct packed {
      plar_status_type status;
      logic            notify;
      logic            link_up;
      logic [2:0]      link_speed;
      logic            negotiating;
   } plar_result_type;

endpackage

// ===== rtl/plar_resolve.sv =====
module plar_resolve (
   input  logic [1:0]               action,
   input  logic [15:0]              bmsr,
   input  logic [15:0]              bmsr_reread,
   input  logic [15:0]              bmcr,
   input  logic [15:0]              anar,
   input  logic [15:0]              anlpar,
   input  logic [15:0]              gig_control,
   input  logic [15:0]              gig_status,
   input  logic                     request_gigabit,
   input  plar_pkg::plar_cfg_type   cfg,
   input  plar_pkg::plar_state_type cur,
   output plar_pkg::plar_state_type nxt,
   output plar_pkg::plar_result_type result
);

   logic [15:0]               common;
   logic [15:0]               gig;
   logic [2:0]                resolved;
   logic [2:0]                forced;
   logic [15:0]               polls_inc;
   logic                      link_low_twice;
   logic                      notify;
   plar_pkg::plar_status_type status;

   // best common mode in priority order
   assign common = anar & anlpar;
   assign gig    = gig_control & (gig_status >> plar_pkg::GIG_STATUS_SHIFT);

   always_comb begin
      if (cfg.gigabit_enabled && gig[9]) begin
         resolved = plar_pkg::SPD_1000F;
      end else if (cfg.gigabit_enabled && gig[8]) begin
         resolved = plar_pkg::SPD_1000H;
      end else if (common[8]) begin
         resolved = plar_pkg::SPD_100F;
      end else if (common[7]) begin
         resolved = plar_pkg::SPD_100H;
      end else if (common[6]) begin
         resolved = plar_pkg::SPD_10F;
      end else begin
         resolved = plar_pkg::SPD_10H;
      end
   end

   // forced speed from bmcr speed select bits, reserved combination gives none
   always_comb begin
      case ({bmcr[13], bmcr[6]})
         2'b00:   forced = bmcr[8] ? plar_pkg::SPD_10F   : plar_pkg::SPD_10H;
         2'b10:   forced = bmcr[8] ? plar_pkg::SPD_100F  : plar_pkg::SPD_100H;
         2'b01:   forced = bmcr[8] ? plar_pkg::SPD_1000F : plar_pkg::SPD_1000H;
         default: forced = plar_pkg::SPD_NONE;
      endcase
   end

   // saturating poll count
   assign polls_inc = (cur.polls_waited == 16'hFFFF) ? cur.polls_waited
                                                     : cur.polls_waited + 16'd1;
   assign link_low_twice = !bmsr[2] && !bmsr_reread[2];

   // next state and status
   always_comb begin
      nxt    = cur;
      status = plar_pkg::ST_SAME;
      notify = 1'b0;
      case (action)
         plar_pkg::ACT_POLL: begin
            if (cur.in_negotiation) begin
               // completion check that may time out
               if (!bmsr[5]) begin
                  nxt.polls_waited = polls_inc;
                  status = (polls_inc >= cfg.autoneg_timeout_polls) ?
                           plar_pkg::ST_TIMEOUT : plar_pkg::ST_NEGOTIATING;
               end else if (link_low_twice) begin
                  status = plar_pkg::ST_SAME;
               end else begin
                  nxt.speed_code = resolved;
                  nxt.is_up      = 1'b1;
                  status         = plar_pkg::ST_CHANGED;
               end
            end else if (!bmsr[2]) begin
               // link went or stays down
               nxt.speed_code = plar_pkg::SPD_NONE;
               nxt.is_up      = 1'b0;
               status = cur.is_up ? plar_pkg::ST_CHANGED : plar_pkg::ST_SAME;
            end else if (!bmcr[12]) begin
               // forced link
               if (forced != cur.speed_code || !cur.is_up) begin
                  nxt.is_up      = 1'b1;
                  nxt.speed_code = forced;
                  status         = plar_pkg::ST_CHANGED;
               end
            end else if (!cur.is_up) begin
               // link came up with autoneg, immediate check without expiry
               nxt.is_up        = 1'b1;
               nxt.polls_waited = 16'd0;
               if (!bmsr[5]) begin
                  status = plar_pkg::ST_NEGOTIATING;
               end else if (link_low_twice) begin
                  status = plar_pkg::ST_SAME;
               end else begin
                  nxt.speed_code = resolved;
                  status         = plar_pkg::ST_CHANGED;
               end
            end
            nxt.in_negotiation = (status == plar_pkg::ST_NEGOTIATING);
            notify             = (status == plar_pkg::ST_CHANGED);
         end
         plar_pkg::ACT_START: begin
            nxt.in_negotiation = 1'b1;
            nxt.polls_waited   = 16'd0;
            status             = plar_pkg::ST_CHANGED;
         end
         plar_pkg::ACT_FORCE: begin
            if (!cfg.gigabit_enabled && request_gigabit) begin
               status = plar_pkg::ST_NOTSUP;
            end else begin
               nxt.in_negotiation = 1'b0;
               status             = plar_pkg::ST_CHANGED;
            end
         end
         default: begin
            status = plar_pkg::ST_SAME;
         end
      endcase
   end

   // reported fields
   assign result.status      = status;
   assign result.notify      = notify;
   assign result.link_up     = nxt.is_up && (nxt.speed_code != plar_pkg::SPD_NONE);
   assign result.link_speed  = nxt.speed_code;
   assign result.negotiating = nxt.in_negotiation;

endmodule

// ===== rtl/phy_link_monitor_autoneg_resolve_core.sv =====
// a transaction accepted into the input register passes the decision logic into the result
//   register, from which rsp can take it
// throughput: one transaction per cycle while rsp_stall does not hold the result register,
//   set by the input register feeding one decision stage into the result register
// reset (synchronous, active high): link down, speed none, not negotiating,
//   poll count zero, gigabit disabled, timeout 50 polls, both stages empty
module phy_link_monitor_autoneg_resolve_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_bmsr,
   input  logic [15:0] req_bmsr_reread,
   input  logic [15:0] req_bmcr,
   input  logic [15:0] req_anar,
   input  logic [15:0] req_anlpar,
   input  logic [15:0] req_gig_control,
   input  logic [15:0] req_gig_status,
   input  logic        req_request_gigabit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_notify,
   output logic        rsp_link_up,
   output logic [2:0]  rsp_link_speed,
   output logic        rsp_negotiating,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   logic                      in_valid_ff;
   logic [1:0]                action_ff;
   logic [15:0]               bmsr_ff;
   logic [15:0]               bmsr_reread_ff;
   logic [15:0]               bmcr_ff;
   logic [15:0]               anar_ff;
   logic [15:0]               anlpar_ff;
   logic [15:0]               gig_control_ff;
   logic [15:0]               gig_status_ff;
   logic                      request_gigabit_ff;
   logic                      out_valid_ff;
   plar_pkg::plar_result_type result_ff;
   plar_pkg::plar_result_type result_in;
   plar_pkg::plar_state_type  state_ff;
   plar_pkg::plar_state_type  state_in;
   plar_pkg::plar_cfg_type    cfg_ff;
   logic                      advance;
   logic                      in_load;

   // pipeline moves when the result register is free or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gigabit_enabled       <= 1'b0;
         cfg_ff.autoneg_timeout_polls <= plar_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            plar_pkg::CSR_GIGABIT_ENABLED: cfg_ff.gigabit_enabled <= csr_write_data[0];
            plar_pkg::CSR_TIMEOUT_POLLS:   cfg_ff.autoneg_timeout_polls <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         action_ff          <= req_action;
         bmsr_ff            <= req_bmsr;
         bmsr_reread_ff     <= req_bmsr_reread;
         bmcr_ff            <= req_bmcr;
         anar_ff            <= req_anar;
         anlpar_ff          <= req_anlpar;
         gig_control_ff     <= req_gig_control;
         gig_status_ff      <= req_gig_status;
         request_gigabit_ff <= req_request_gigabit;
      end
   end

   // decision logic
   plar_resolve u_resolve (
      .action          (action_ff),
      .bmsr            (bmsr_ff),
      .bmsr_reread     (bmsr_reread_ff),
      .bmcr            (bmcr_ff),
      .anar            (anar_ff),
      .anlpar          (anlpar_ff),
      .gig_control     (gig_control_ff),
      .gig_status      (gig_status_ff),
      .request_gigabit (request_gigabit_ff),
      .cfg             (cfg_ff),
      .cur             (state_ff),
      .nxt             (state_in),
      .result          (result_in)
   );

   // link state, updated as each transaction moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (in_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = result_ff.status;
   assign rsp_notify      = result_ff.notify;
   assign rsp_link_up     = result_ff.link_up;
   assign rsp_link_speed  = result_ff.link_speed;
   assign rsp_negotiating = result_ff.negotiating;

`ifndef SYNTH
   // reported link is never up without a speed
   a_link_needs_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_link_up |-> rsp_link_speed != plar_pkg::SPD_NONE)
      else $error("link up reported with no speed");

   // notify only accompanies a changed status
   a_notify_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notify |-> rsp_status == plar_pkg::ST_CHANGED)
      else $error("notify without changed status");

   // a timeout always ends negotiation
   a_timeout_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == plar_pkg::ST_TIMEOUT |-> !rsp_negotiating)
      else $error("timeout left negotiation running");

   // stall toward the requester only when the input stage is held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled with pipeline free");

   // both stages empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");
`endif

endmodule
